// ===== design/bfpw_pkg.sv =====
// bfpw_pkg: shared types, widths and register codes of the forward pixel warp
// depends on nothing; used by the channel interfaces and the top level
`default_nettype none

package bfpw_pkg;

    // fixed field widths
    localparam int COEF_W       = 48;
    localparam int FRAC_W       = 32;
    localparam int NUM_COEF     = 8;
    localparam int CFG_IDX_W    = 3;
    localparam int SRC_COORD_W  = 12;
    localparam int COLOUR_W     = 8;
    localparam int DEST_COORD_W = 10;
    localparam int DEST_INDEX_W = 20;

    // defaults for the top level parameters
    localparam int DEF_DEST_WIDTH  = 1024;
    localparam int DEF_DEST_HEIGHT = 1024;
    localparam int DEF_COORD_BITS  = 12;

    typedef logic signed [COEF_W-1:0] t_coef;

    // coefficient register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        COEF_X_CONST,
        COEF_X_FROM_X,
        COEF_X_FROM_Y,
        COEF_X_FROM_XY,
        COEF_Y_CONST,
        COEF_Y_FROM_X,
        COEF_Y_FROM_Y,
        COEF_Y_FROM_XY
    } t_coef_idx;

    // 1.0 in signed fixed point with 32 fraction bits
    localparam t_coef COEF_ONE = t_coef'(64'h0000_0001_0000_0000);

    // colour bytes travelling alongside the coordinates
    typedef struct packed {
        logic [COLOUR_W-1:0] red;
        logic [COLOUR_W-1:0] green;
        logic [COLOUR_W-1:0] blue;
    } t_colour;

    // identity mapping after reset
    function automatic t_coef coef_reset(input logic [CFG_IDX_W-1:0] idx);
        t_coef res;
        res = '0;
        if (idx == COEF_X_FROM_X || idx == COEF_Y_FROM_Y) begin
            res = COEF_ONE;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== design/bfpw_if.sv =====
// bfpw channel interfaces: source pixel, warped pixel and coefficient write channels
// depends on bfpw_pkg
`default_nettype none

interface bfpw_pix_in_if import bfpw_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [SRC_COORD_W-1:0] src_x;
    logic [SRC_COORD_W-1:0] src_y;
    logic [COLOUR_W-1:0]    src_red;
    logic [COLOUR_W-1:0]    src_green;
    logic [COLOUR_W-1:0]    src_blue;

    modport source (output valid, src_x, src_y, src_red, src_green, src_blue, input ready);
    modport sink   (input valid, src_x, src_y, src_red, src_green, src_blue, output ready);
endinterface

interface bfpw_pix_out_if import bfpw_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [DEST_COORD_W-1:0] dest_x;
    logic [DEST_COORD_W-1:0] dest_y;
    logic [DEST_INDEX_W-1:0] dest_index;
    logic [COLOUR_W-1:0]     dest_red;
    logic [COLOUR_W-1:0]     dest_green;
    logic [COLOUR_W-1:0]     dest_blue;

    modport source (output valid, dest_x, dest_y, dest_index, dest_red, dest_green,
                    dest_blue, input ready);
    modport sink   (input valid, dest_x, dest_y, dest_index, dest_red, dest_green,
                    dest_blue, output ready);
endinterface

interface bfpw_cfg_if import bfpw_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [COEF_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/bilinear_forward_pixel_warp.sv =====
// Forward bilinear pixel warp: maps source pixels into the destination frame.
// An accepted transaction moves through the stages in order to its result (when it lands in frame).
// Throughput: one pixel per cycle; each of the 7 pipeline stages holds one pixel and
// empty stages close up while the output is stalled.
// Reset: clears all valid bits and loads the identity mapping into the coefficients.
// Depends on bfpw_pkg and the channel interfaces in bfpw_if.sv.
`default_nettype none

module bilinear_forward_pixel_warp import bfpw_pkg::*; #(
    parameter int DEST_WIDTH  = DEF_DEST_WIDTH,
    parameter int DEST_HEIGHT = DEF_DEST_HEIGHT,
    parameter int COORD_BITS  = DEF_COORD_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    bfpw_pix_in_if.sink      i_pix,
    bfpw_pix_out_if.source   o_pix,
    bfpw_cfg_if.sink         i_cfg
);

    // derived widths
    localparam int XW     = (COORD_BITS < SRC_COORD_W) ? COORD_BITS : SRC_COORD_W;
    localparam int PW     = COEF_W + XW + 1;
    localparam int SUM_W  = COEF_W + 2 * XW + 2;
    localparam int IP_W   = SUM_W - FRAC_W;
    localparam int DXW    = (DEST_WIDTH > 1) ? $clog2(DEST_WIDTH) : 1;
    localparam int DYW    = (DEST_HEIGHT > 1) ? $clog2(DEST_HEIGHT) : 1;
    localparam int WID_W  = $clog2(DEST_WIDTH + 1);
    localparam int IDX_W  = (DYW + WID_W + 1 > DEST_INDEX_W) ? (DYW + WID_W + 1)
                                                              : DEST_INDEX_W;
    localparam int NSTG   = 6;

    // coefficient registers
    t_coef r_coef [NUM_COEF];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COEF; i++) begin
                r_coef[i] <= coef_reset(CFG_IDX_W'(i));
            end
        end else if (i_cfg.valid) begin
            r_coef[i_cfg.index] <= t_coef'(i_cfg.data);
        end
    end

    // stage enables: a stage loads when it is empty or the one after it moves
    logic [NSTG-1:0] r_v;
    logic            r_ov;
    logic            r6_ok;
    logic [NSTG:0]   w_en;

    always_comb begin
        w_en[NSTG] = !r_ov || o_pix.ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign i_pix.ready = w_en[0];

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_pix.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            if (w_en[NSTG]) begin
                r_ov <= r_v[NSTG-1] && r6_ok;
            end
        end
    end

    // stage 1: register masked coordinates and colour
    logic [XW-1:0] r1_x, r1_y;
    t_colour       r1_col;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_x   <= i_pix.src_x[XW-1:0];
            r1_y   <= i_pix.src_y[XW-1:0];
            r1_col <= '{red: i_pix.src_red, green: i_pix.src_green, blue: i_pix.src_blue};
        end
    end

    // stage 2: product of the coordinates
    logic [XW-1:0]   r2_x, r2_y;
    logic [2*XW-1:0] r2_xy;
    t_colour         r2_col;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r2_x   <= r1_x;
            r2_y   <= r1_y;
            r2_xy  <= (2*XW)'(r1_x) * (2*XW)'(r1_y);
            r2_col <= r1_col;
        end
    end

    // stage 3: coefficient products, x*y term split into two halves
    logic signed [XW:0] w_sx, w_sy, w_sxy_lo, w_sxy_hi;
    logic signed [PW-1:0] n3_px [4];
    logic signed [PW-1:0] n3_py [4];
    logic signed [PW-1:0] r3_px [4];
    logic signed [PW-1:0] r3_py [4];
    t_colour              r3_col;

    always_comb begin
        w_sx     = $signed({1'b0, r2_x});
        w_sy     = $signed({1'b0, r2_y});
        w_sxy_lo = $signed({1'b0, r2_xy[XW-1:0]});
        w_sxy_hi = $signed({1'b0, r2_xy[2*XW-1:XW]});
        n3_px[0] = r_coef[COEF_X_FROM_X]  * w_sx;
        n3_px[1] = r_coef[COEF_X_FROM_Y]  * w_sy;
        n3_px[2] = r_coef[COEF_X_FROM_XY] * w_sxy_lo;
        n3_px[3] = r_coef[COEF_X_FROM_XY] * w_sxy_hi;
        n3_py[0] = r_coef[COEF_Y_FROM_X]  * w_sx;
        n3_py[1] = r_coef[COEF_Y_FROM_Y]  * w_sy;
        n3_py[2] = r_coef[COEF_Y_FROM_XY] * w_sxy_lo;
        n3_py[3] = r_coef[COEF_Y_FROM_XY] * w_sxy_hi;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r3_px  <= n3_px;
            r3_py  <= n3_py;
            r3_col <= r2_col;
        end
    end

    // stage 4: partial sums
    logic signed [SUM_W-1:0] n4_ax, n4_bx, n4_ay, n4_by;
    logic signed [SUM_W-1:0] r4_ax, r4_bx, r4_ay, r4_by;
    t_colour                 r4_col;

    always_comb begin
        n4_ax = SUM_W'(r_coef[COEF_X_CONST]) + SUM_W'(r3_px[0]) + SUM_W'(r3_px[1]);
        n4_bx = SUM_W'(r3_px[2]) + (SUM_W'(r3_px[3]) <<< XW);
        n4_ay = SUM_W'(r_coef[COEF_Y_CONST]) + SUM_W'(r3_py[0]) + SUM_W'(r3_py[1]);
        n4_by = SUM_W'(r3_py[2]) + (SUM_W'(r3_py[3]) <<< XW);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r4_ax  <= n4_ax;
            r4_bx  <= n4_bx;
            r4_ay  <= n4_ay;
            r4_by  <= n4_by;
            r4_col <= r3_col;
        end
    end

    // stage 5: full sums in fixed point
    logic signed [SUM_W-1:0] r5_sx, r5_sy;
    t_colour                 r5_col;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r5_sx  <= r4_ax + r4_bx;
            r5_sy  <= r4_ay + r4_by;
            r5_col <= r4_col;
        end
    end

    // stage 6: truncate toward zero and check against the frame
    logic [IP_W-1:0] w_ipx, w_ipy;
    logic            n6_okx, n6_oky;
    logic [DXW-1:0]  n6_dx, r6_dx;
    logic [DYW-1:0]  n6_dy, r6_dy;
    t_colour         r6_col;

    always_comb begin
        w_ipx = r5_sx[SUM_W-1:FRAC_W];
        w_ipy = r5_sy[SUM_W-1:FRAC_W];
        // negative sums: only a fraction above -1 survives, as zero
        if (r5_sx[SUM_W-1]) begin
            n6_okx = (w_ipx == '1) && (r5_sx[FRAC_W-1:0] != '0);
            n6_dx  = '0;
        end else begin
            n6_okx = w_ipx < IP_W'(DEST_WIDTH);
            n6_dx  = w_ipx[DXW-1:0];
        end
        if (r5_sy[SUM_W-1]) begin
            n6_oky = (w_ipy == '1) && (r5_sy[FRAC_W-1:0] != '0);
            n6_dy  = '0;
        end else begin
            n6_oky = w_ipy < IP_W'(DEST_HEIGHT);
            n6_dy  = w_ipy[DYW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r6_dx  <= n6_dx;
            r6_dy  <= n6_dy;
            r6_ok  <= n6_okx && n6_oky;
            r6_col <= r5_col;
        end
    end

    // stage 7: linear index and output register
    logic [IDX_W-1:0] n7_index, n7_dx, n7_dy;
    logic [DEST_COORD_W-1:0] r7_dx, r7_dy;
    logic [DEST_INDEX_W-1:0] r7_index;
    t_colour                 r7_col;

    always_comb begin
        n7_dx    = IDX_W'(r6_dx);
        n7_dy    = IDX_W'(r6_dy);
        n7_index = n7_dy * IDX_W'(DEST_WIDTH) + n7_dx;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NSTG]) begin
            r7_dx    <= n7_dx[DEST_COORD_W-1:0];
            r7_dy    <= n7_dy[DEST_COORD_W-1:0];
            r7_index <= n7_index[DEST_INDEX_W-1:0];
            r7_col   <= r6_col;
        end
    end

    assign o_pix.valid      = r_ov;
    assign o_pix.dest_x     = r7_dx;
    assign o_pix.dest_y     = r7_dy;
    assign o_pix.dest_index = r7_index;
    assign o_pix.dest_red   = r7_col.red;
    assign o_pix.dest_green = r7_col.green;
    assign o_pix.dest_blue  = r7_col.blue;

    // an accepted transaction always occupies the first stage next cycle
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix.valid && i_pix.ready |=> r_v[0])
        else $error("accepted transaction missing from first stage");

    // a full pipeline behind a stalled output takes nothing more
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_v) && r_ov && !o_pix.ready |-> !i_pix.ready)
        else $error("input taken while pipeline is full and stalled");

    // a result column always lies inside the frame
    a_x_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> IDX_W'(o_pix.dest_x) < IDX_W'(DEST_WIDTH))
        else $error("result column outside the destination frame");

    // a result row always lies inside the frame
    a_y_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> IDX_W'(o_pix.dest_y) < IDX_W'(DEST_HEIGHT))
        else $error("result row outside the destination frame");

endmodule

`default_nettype wire
